FILE: hw/rtl/wraparound_timed_event_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed event queue
// Shared concurrent-check forms, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WRAPAROUND_TIMED_EVENT_QUEUE_TOP_ASSERT_SVH
`define WRAPAROUND_TIMED_EVENT_QUEUE_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define WTEQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check a consequence in the clock after the antecedent.
`define WTEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check a consequence in the same clock as the antecedent.
`define WTEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/wteq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wteq_pkg
// Types, constants and the wraparound ordering function of the event queue.
// ----------------------------------------------------------------------------
package wteq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int DUE_W        = 32;
  localparam int KIND_W       = 4;
  localparam int CMD_W        = 3;
  localparam int HELD_W       = 5;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 80;

  localparam logic [DUE_W-1:0] HALF_RANGE   = 32'h8000_0000;
  localparam logic [DUE_W-1:0] STALE_WINDOW = 32'h1000_0000;

  localparam logic [CMD_W-1:0] CMD_ADD_DELAY = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_AT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } wteq_state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE
  } wteq_op_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    wteq_op_t              op;
    logic [DUE_W-1:0]      new_due;
    logic [KIND_W-1:0]     new_kind;
    logic [DUE_W-1:0]      a_rel;
    logic [DUE_W-1:0]      now;
    logic [KIND_W-1:0]     spec_type;
    logic                  spec_done;
    logic                  spec_add;
    logic [KIND_W-1:0]     tgt_kind;
  } wteq_ctl_t;

  // True when a new event (a_rel = due - now) belongs before stored entry b.
  function automatic logic goes_before(
    input logic [DUE_W-1:0]  a_rel,
    input logic [DUE_W-1:0]  b,
    input logic [KIND_W-1:0] kind_b,
    input logic [DUE_W-1:0]  now,
    input logic [KIND_W-1:0] spec_type,
    input logic              spec_done
  );
    logic [DUE_W-1:0] b_rel;
    logic [DUE_W-1:0] b_age;
    logic             res;
    b_rel = b - now;
    b_age = now - b;
    if (a_rel >= HALF_RANGE) begin
      res = 1'b0;
    end else if (b_rel < HALF_RANGE) begin
      res = (a_rel < b_rel);
    end else if (b_age < STALE_WINDOW) begin
      res = (kind_b == spec_type) && spec_done;
    end else begin
      res = 1'b1;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/wraparound_timed_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wraparound_timed_event_queue_top
// Ordered queue of timed events kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Each input transaction carries one command (add by delay, add at time, pop,
// remove first of a type, find time of a type, clear) and returns exactly one
// result transaction with the next deadline, the found time, the head type and
// valid flag, the entry count and the overflow flag. The accept clock registers
// the command and forms its due time and its distance from now; in the execute
// state every cell compares its entry at once, a priority chain along the row
// picks the insert or delete slot, the row shifts by one and the result
// register loads. The next command is accepted while a result still waits; it
// completes once that result is taken. Entries at or beyond the entry count
// are never read, so the cells need no clearing after reset. The user writes
// special_type on the cfg channel while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module wraparound_timed_event_queue_top
  import wteq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // cfg channel: special_type [3:0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [KIND_W-1:0]      cfg_data,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: event_type [3:0], time_value [35:4], now [67:36], zero pad [71:68]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: command [2:0]
  input  logic [CMD_W-1:0]       in_tuser,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: next_deadline [31:0], found_time [63:32], head_type [67:64],
  //        head_valid [68], entries_held [73:69], overflow [74], zero pad [79:75]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

`include "wraparound_timed_event_queue_top_assert.svh"

  // Control state.
  wteq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic               sdone_r, sdone_nxt;
  logic [DUE_W-1:0]   dl_r, dl_nxt;
  logic [KIND_W-1:0]  stype_r;
  logic               out_valid_r;

  // Registered command.
  logic [CMD_W-1:0]   cmd_r;
  logic [KIND_W-1:0]  item_kind_r;
  logic [DUE_W-1:0]   item_due_r;
  logic [DUE_W-1:0]   item_arel_r;
  logic [DUE_W-1:0]   item_now_r;

  // Result register.
  logic [DUE_W-1:0]   out_dl_r;
  logic [DUE_W-1:0]   out_found_r;
  logic [KIND_W-1:0]  out_htype_r;
  logic               out_hv_r;
  logic [HELD_W-1:0]  out_cnt_r;
  logic               out_ovf_r;

  logic               accept;
  logic               commit;
  logic               is_add;
  logic               full;
  logic               chain_in;
  logic               ovf_nxt;
  logic [DUE_W-1:0]   found_nxt;
  logic [KIND_W-1:0]  htype_nxt;
  logic [DUE_W-1:0]   head2_due;
  wteq_ctl_t          ctl;

  logic [KIND_W-1:0]  in_kind;
  logic [DUE_W-1:0]   in_tval;
  logic [DUE_W-1:0]   in_now;

  // Row wiring.
  logic               seen   [QUEUE_DEPTH+1];
  logic [DUE_W-1:0]   found  [QUEUE_DEPTH+1];
  logic [DUE_W-1:0]   due_q  [QUEUE_DEPTH];
  logic [KIND_W-1:0]  kind_q [QUEUE_DEPTH];
  logic [KIND_W-1:0]  kind_nx[QUEUE_DEPTH];
  logic               vld    [QUEUE_DEPTH];

  assign in_kind = in_tdata[3:0];
  assign in_tval = in_tdata[35:4];
  assign in_now  = in_tdata[67:36];

  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EXEC: commit    = !out_valid_r || out_tready;
      default: begin
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the command; form the due time and its distance from now.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_tuser;
      item_kind_r <= in_kind;
      item_now_r  <= in_now;
      if (in_tuser == CMD_ADD_DELAY) begin
        item_due_r  <= in_now + in_tval;
        item_arel_r <= in_tval;
      end else begin
        item_due_r  <= in_tval;
        item_arel_r <= in_tval - in_now;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cell control broadcast
  // --------------------------------------------------------------------------
  assign is_add = (cmd_r == CMD_ADD_DELAY) || (cmd_r == CMD_ADD_AT);
  assign full   = (occ_r >= CNT_W'(QUEUE_DEPTH));

  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.new_due   = item_due_r;
    ctl.new_kind  = item_kind_r;
    ctl.a_rel     = item_arel_r;
    ctl.now       = item_now_r;
    ctl.spec_type = stype_r;
    // A late "now" retires the special-done mark before the add compares.
    ctl.spec_done = sdone_r && !(item_now_r > HALF_RANGE);
    ctl.spec_add  = (item_kind_r == stype_r);
    ctl.tgt_kind  = item_kind_r;
    chain_in      = 1'b0;
    if (commit) begin
      unique case (cmd_r)
        CMD_ADD_DELAY, CMD_ADD_AT: begin
          if (!full) ctl.op = OP_INSERT;
        end
        CMD_POP: begin
          // Force the whole row to shift toward the head.
          if (occ_r != '0) begin
            ctl.op   = OP_DELETE;
            chain_in = 1'b1;
          end
        end
        CMD_REMOVE: ctl.op = OP_DELETE;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Row of cells
  // --------------------------------------------------------------------------
  assign seen[0]  = chain_in;
  assign found[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [DUE_W-1:0]  left_due, right_due;
    logic [KIND_W-1:0] left_kind, right_kind;

    assign vld[i] = (CNT_W'(i) < occ_r);

    if (i == 0) begin : g_first
      assign left_due  = item_due_r;
      assign left_kind = item_kind_r;
    end else begin : g_mid_l
      assign left_due  = due_q[i-1];
      assign left_kind = kind_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_due  = due_q[i];
      assign right_kind = kind_q[i];
    end else begin : g_mid_r
      assign right_due  = due_q[i+1];
      assign right_kind = kind_q[i+1];
    end

    wteq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .valid_i      (vld[i]),
      .seen_i       (seen[i]),
      .found_i      (found[i]),
      .left_due_i   (left_due),
      .left_kind_i  (left_kind),
      .right_due_i  (right_due),
      .right_kind_i (right_kind),
      .seen_o       (seen[i+1]),
      .found_o      (found[i+1]),
      .due_o        (due_q[i]),
      .kind_o       (kind_q[i]),
      .kind_nxt_o   (kind_nx[i])
    );
  end

  // --------------------------------------------------------------------------
  // Queue bookkeeping and result
  // --------------------------------------------------------------------------
  assign head2_due = due_q[1];

  always_comb begin
    occ_nxt   = occ_r;
    dl_nxt    = dl_r;
    sdone_nxt = sdone_r;
    ovf_nxt   = 1'b0;
    found_nxt = '0;
    unique case (cmd_r)
      CMD_ADD_DELAY, CMD_ADD_AT: begin
        if (item_now_r > HALF_RANGE) sdone_nxt = 1'b0;
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          occ_nxt = occ_r + CNT_W'(1);
          // New head: cell zero took the new entry.
          if (seen[1]) dl_nxt = item_due_r;
        end
      end
      CMD_POP: begin
        if (occ_r != '0) begin
          occ_nxt = occ_r - CNT_W'(1);
          if (kind_q[0] == stype_r) sdone_nxt = 1'b1;
          if ((occ_r > CNT_W'(1)) && ((head2_due > item_now_r) ||
              ((item_now_r - head2_due) < HALF_RANGE))) begin
            dl_nxt = head2_due;
          end else begin
            dl_nxt = '0;
          end
        end
      end
      CMD_REMOVE: begin
        if (seen[QUEUE_DEPTH]) occ_nxt = occ_r - CNT_W'(1);
      end
      CMD_FIND:  found_nxt = found[QUEUE_DEPTH];
      CMD_CLEAR: occ_nxt   = '0;
      default: begin
      end
    endcase
  end

  assign htype_nxt = (occ_nxt != '0) ? kind_nx[0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      sdone_r     <= 1'b1;
      dl_r        <= '0;
      stype_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) stype_r <= cfg_data;
      if (commit) begin
        occ_r       <= occ_nxt;
        sdone_r     <= sdone_nxt;
        dl_r        <= dl_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_dl_r    <= dl_nxt;
      out_found_r <= found_nxt;
      out_htype_r <= htype_nxt;
      out_hv_r    <= (occ_nxt != '0);
      out_cnt_r   <= HELD_W'(occ_nxt);
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_ovf_r, out_cnt_r, out_hv_r, out_htype_r,
                       out_found_r, out_dl_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `WTEQ_ASSERT_ALWAYS(a_occ_bound, occ_r <= CNT_W'(QUEUE_DEPTH),
    "entry count above queue depth")
  `WTEQ_ASSERT_SAME(a_ovf_full, out_valid_r && out_ovf_r,
    occ_r == CNT_W'(QUEUE_DEPTH), "overflow reported on a queue that is not full")
  `WTEQ_ASSERT_SAME(a_head_valid, out_valid_r, out_hv_r == (occ_r != '0),
    "head valid disagrees with entry count")
  `WTEQ_ASSERT_NEXT(a_pop_dec, commit && (cmd_r == CMD_POP) && (occ_r != '0),
    occ_r == $past(occ_r) - CNT_W'(1), "pop did not drop exactly one entry")

endmodule

FILE: hw/rtl/wteq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wteq_cell
// One queue slot: holds an entry, compares it and shifts with its neighbors.
// ----------------------------------------------------------------------------
module wteq_cell
  import wteq_pkg::*;
(
  input  logic              clk,
  input  wteq_ctl_t         ctl,
  input  logic              valid_i,
  input  logic              seen_i,
  input  logic [DUE_W-1:0]  found_i,
  input  logic [DUE_W-1:0]  left_due_i,
  input  logic [KIND_W-1:0] left_kind_i,
  input  logic [DUE_W-1:0]  right_due_i,
  input  logic [KIND_W-1:0] right_kind_i,
  output logic              seen_o,
  output logic [DUE_W-1:0]  found_o,
  output logic [DUE_W-1:0]  due_o,
  output logic [KIND_W-1:0] kind_o,
  output logic [KIND_W-1:0] kind_nxt_o
);

  logic [DUE_W-1:0]  due_r, due_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              match, gb, stop;

  assign match = valid_i && (kind_r == ctl.tgt_kind);
  assign gb    = goes_before(ctl.a_rel, due_r, kind_r, ctl.now, ctl.spec_type,
                             ctl.spec_done);

  // Insert stops at the first slot it goes before, or the first empty one.
  always_comb begin
    if (ctl.op == OP_INSERT) begin
      stop = valid_i ? (!ctl.spec_add && gb) : 1'b1;
    end else begin
      stop = match;
    end
  end

  assign seen_o  = seen_i | stop;
  assign found_o = (match && !seen_i) ? due_r : found_i;

  always_comb begin
    due_nxt  = due_r;
    kind_nxt = kind_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (seen_i) begin
          due_nxt  = left_due_i;
          kind_nxt = left_kind_i;
        end else if (stop) begin
          due_nxt  = ctl.new_due;
          kind_nxt = ctl.new_kind;
        end
      end
      OP_DELETE: begin
        if (seen_i || stop) begin
          due_nxt  = right_due_i;
          kind_nxt = right_kind_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    due_r  <= due_nxt;
    kind_r <= kind_nxt;
  end

  assign due_o      = due_r;
  assign kind_o     = kind_r;
  assign kind_nxt_o = kind_nxt;

endmodule

FILE: sim/wraparound_timed_event_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wraparound_timed_event_queue_top_test
// Self-checking bench for the wraparound timed event queue.
// ----------------------------------------------------------------------------
// A short directed plan walks the corner cases first: empty-queue commands,
// the spare command codes, wraparound and stale ordering, the special-type
// tail rule with both states of the special-done flag, and a full queue that
// drops an add. Random command sequences follow, in fill, drain and mixed
// segments, across several special_type settings. Every accepted command is
// run through a local model of the queue, and every result transaction is
// compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module wraparound_timed_event_queue_top_test;
  import wteq_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RANDOM_ITEMS  = 192;   // per special_type setting
  localparam int SETTINGS_RUN  = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 450;   // start the long receiver stall here
  localparam int SHOW_LIMIT    = 10;

  // Command codes the block leaves unused; they must act as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  // One result transaction, unpacked from out_tdata.
  typedef struct packed {
    logic [DUE_W-1:0]  deadline;
    logic [DUE_W-1:0]  found;
    logic [KIND_W-1:0] head_kind;
    logic              head_ok;
    logic [HELD_W-1:0] held;
    logic              dropped;
  } queue_status_t;

  localparam queue_status_t ALL_ZERO = '0;

  // Status fixed by hand for a directed row, or left to the model.
  typedef struct {
    bit            typed;
    queue_status_t want;
  } pinned_status_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [KIND_W-1:0] kind;
    logic [DUE_W-1:0]  tval;
    logic [DUE_W-1:0]  tnow;
    int                reps;
    bit                typed;
    queue_status_t     want;
  } plan_row_t;

  typedef enum logic [1:0] {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_mode_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RHYTHM} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [KIND_W-1:0]      cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Local copy of the queue contents and registers.
  logic [DUE_W-1:0]  q_due  [QUEUE_DEPTH];
  logic [KIND_W-1:0] q_kind [QUEUE_DEPTH];
  int                q_count;
  bit                spec_done;
  logic [DUE_W-1:0]  deadline_copy;
  logic [KIND_W-1:0] spec_kind;

  queue_status_t  pending_status [$];
  pinned_status_t pinned_status  [$];

  int        fail_count;
  int        items_sent;
  int        burst_left;
  bit        rx_hold;
  logic [DUE_W-1:0] now_cnt;
  seg_mode_t seg_mode;
  int        seg_left;

  // Directed plan. Special_type is at its reset value 0 throughout.
  plan_row_t plan [29] = '{
    // empty queue right after reset: every command reports all zeros
    '{CMD_POP,       4'd0,  32'd0,          32'd0,          1, 1'b1, ALL_ZERO},
    '{CMD_FIND,      4'd5,  32'd0,          32'd0,          1, 1'b1, ALL_ZERO},
    '{CMD_REMOVE,    4'd5,  32'd0,          32'd0,          1, 1'b1, ALL_ZERO},
    '{CMD_SPARE6,    4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1, 1'b1, ALL_ZERO},
    '{CMD_SPARE7,    4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1, 1'b1, ALL_ZERO},
    // first add becomes the head and sets the deadline
    '{CMD_ADD_AT,    4'd3,  32'd100,        32'd0,          1, 1'b1,
      '{32'd100, 32'd0, 4'd3, 1'b1, 5'd1, 1'b0}},
    '{CMD_ADD_DELAY, 4'd1,  32'd0,          32'd0,          1, 1'b0, ALL_ZERO},
    '{CMD_ADD_DELAY, 4'd4,  32'd50,         32'd10,         1, 1'b0, ALL_ZERO},
    // special type walks to the tail even though it is due first
    '{CMD_ADD_DELAY, 4'd0,  32'd1,          32'd10,         1, 1'b0, ALL_ZERO},
    // equal due time steps past the entry already there
    '{CMD_ADD_AT,    4'd4,  32'd100,        32'd10,         1, 1'b0, ALL_ZERO},
    '{CMD_FIND,      4'd3,  32'd0,          32'd20,         1, 1'b0, ALL_ZERO},
    // largest delay at the top of the counter; now past half clears the flag
    '{CMD_ADD_DELAY, 4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1, 1'b0, ALL_ZERO},
    '{CMD_POP,       4'd0,  32'd0,          32'd70,         1, 1'b0, ALL_ZERO},
    '{CMD_REMOVE,    4'd0,  32'd0,          32'd70,         1, 1'b0, ALL_ZERO},
    '{CMD_CLEAR,     4'd0,  32'd0,          32'd70,         1, 1'b0, ALL_ZERO},
    // overdue special head with the flag clear stays ahead of a new event
    '{CMD_ADD_AT,    4'd0,  32'd1000,       32'd900,        1, 1'b0, ALL_ZERO},
    '{CMD_ADD_DELAY, 4'd6,  32'd5,          32'd1100,       1, 1'b0, ALL_ZERO},
    '{CMD_POP,       4'd0,  32'd0,          32'd1100,       1, 1'b0, ALL_ZERO},
    '{CMD_CLEAR,     4'd0,  32'd0,          32'd1100,       1, 1'b0, ALL_ZERO},
    // overdue special head with the flag set yields to a new event
    '{CMD_ADD_AT,    4'd0,  32'd2000,       32'd1990,       1, 1'b0, ALL_ZERO},
    '{CMD_ADD_DELAY, 4'd7,  32'd10,         32'd2100,       1, 1'b0, ALL_ZERO},
    // entries far in the past always lose
    '{CMD_ADD_DELAY, 4'd8,  32'd3,          32'h3000_0000,  1, 1'b0, ALL_ZERO},
    // pop leaves a head more than half a wrap behind: deadline drops to zero
    '{CMD_POP,       4'd0,  32'd0,          32'h9000_0000,  1, 1'b0, ALL_ZERO},
    '{CMD_CLEAR,     4'd0,  32'd0,          32'd0,          1, 1'b0, ALL_ZERO},
    // fill to the brim, then one more add is dropped
    '{CMD_ADD_DELAY, 4'd9,  32'd500,        32'h1234_5678,  16, 1'b0, ALL_ZERO},
    '{CMD_ADD_DELAY, 4'd9,  32'd500,        32'h1234_5678,  1, 1'b1,
      '{32'h1234_586C, 32'd0, 4'd9, 1'b1, 5'd16, 1'b1}},
    '{CMD_FIND,      4'd9,  32'd0,          32'h1234_5678,  1, 1'b0, ALL_ZERO},
    '{CMD_REMOVE,    4'd9,  32'd0,          32'h1234_5678,  1, 1'b0, ALL_ZERO},
    '{CMD_CLEAR,     4'd0,  32'd0,          32'd0,          1, 1'b0, ALL_ZERO}
  };

  wraparound_timed_event_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Queue model
  // --------------------------------------------------------------------------

  // Wraparound order: does new due time a belong ahead of stored entry b?
  function automatic bit ahead_of(input logic [DUE_W-1:0] a, input logic [DUE_W-1:0] b,
                                  input logic [KIND_W-1:0] kind_b,
                                  input logic [DUE_W-1:0] tnow);
    logic [DUE_W-1:0] a_rel;
    logic [DUE_W-1:0] b_rel;
    logic [DUE_W-1:0] b_age;
    a_rel = a - tnow;
    b_rel = b - tnow;
    b_age = tnow - b;
    if (a_rel >= HALF_RANGE) return 1'b0;
    if (b_rel < HALF_RANGE) return a_rel < b_rel;
    // recently overdue: only a special entry may be passed, once it is done
    if (b_age < STALE_WINDOW) return (kind_b == spec_kind) && spec_done;
    return 1'b1;
  endfunction

  function automatic void shift_in(input int pos, input logic [DUE_W-1:0] due,
                                   input logic [KIND_W-1:0] kind);
    for (int i = q_count; i > pos; i--) begin
      q_due[i]  = q_due[i-1];
      q_kind[i] = q_kind[i-1];
    end
    q_due[pos]  = due;
    q_kind[pos] = kind;
    q_count++;
  endfunction

  function automatic void drop_at(input int pos);
    for (int i = pos; i + 1 < q_count; i++) begin
      q_due[i]  = q_due[i+1];
      q_kind[i] = q_kind[i+1];
    end
    q_count--;
  endfunction

  function automatic int first_of_kind(input logic [KIND_W-1:0] kind);
    for (int i = 0; i < q_count; i++)
      if (q_kind[i] == kind) return i;
    return q_count;
  endfunction

  // Apply one command to the model and return the status it reports.
  function automatic queue_status_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [KIND_W-1:0] kind,
                                                  input logic [DUE_W-1:0] tval,
                                                  input logic [DUE_W-1:0] tnow);
    queue_status_t    r;
    logic [DUE_W-1:0] due;
    bit               is_spec;
    int               pos;
    r       = '0;
    is_spec = (kind == spec_kind);
    due     = (cmd == CMD_ADD_DELAY) ? tnow + tval : tval;
    case (cmd)
      CMD_ADD_DELAY, CMD_ADD_AT: begin
        if (tnow > HALF_RANGE) spec_done = 1'b0;
        if (q_count >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else if (q_count == 0 || (!is_spec && ahead_of(due, q_due[0], q_kind[0], tnow)))
        begin
          shift_in(0, due, kind);
          deadline_copy = due;
        end else begin
          pos = 0;
          while (pos + 1 < q_count &&
                 (is_spec || !ahead_of(due, q_due[pos+1], q_kind[pos+1], tnow)))
            pos++;
          // a normal event lands behind any entries sharing its due time
          if (pos + 1 < q_count && !is_spec)
            while (pos + 1 < q_count && q_due[pos+1] == due) pos++;
          shift_in(pos + 1, due, kind);
        end
      end
      CMD_POP: begin
        if (q_count != 0) begin
          if (q_kind[0] == spec_kind) spec_done = 1'b1;
          drop_at(0);
          if (q_count != 0 && (q_due[0] > tnow || (tnow - q_due[0]) < HALF_RANGE))
            deadline_copy = q_due[0];
          else
            deadline_copy = '0;
        end
      end
      CMD_REMOVE: begin
        pos = first_of_kind(kind);
        if (pos < q_count) drop_at(pos);
      end
      CMD_FIND: begin
        pos = first_of_kind(kind);
        if (pos < q_count) r.found = q_due[pos];
      end
      CMD_CLEAR: q_count = 0;
      default: ;
    endcase
    r.deadline  = deadline_copy;
    r.head_kind = (q_count != 0) ? q_kind[0] : '0;
    r.head_ok   = (q_count != 0);
    r.held      = HELD_W'(q_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------

  task automatic score_result(input logic [OUT_TDATA_W-1:0] d);
    queue_status_t seen;
    queue_status_t want;
    seen.deadline  = d[31:0];
    seen.found     = d[63:32];
    seen.head_kind = d[67:64];
    seen.head_ok   = d[68];
    seen.held      = d[73:69];
    seen.dropped   = d[74];
    if (pending_status.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
        $display("%0t: result with no command pending: %p", $realtime, seen);
    end else begin
      want = pending_status.pop_front();
      if (seen.deadline !== want.deadline || seen.found !== want.found ||
          seen.head_kind !== want.head_kind || seen.head_ok !== want.head_ok ||
          seen.held !== want.held || seen.dropped !== want.dropped) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
          $display("%0t: status mismatch", $realtime);
          $display("  expected deadline=%h found=%h head=%0d ok=%b held=%0d drop=%b",
                   want.deadline, want.found, want.head_kind, want.head_ok,
                   want.held, want.dropped);
          $display("  actual   deadline=%h found=%h head=%0d ok=%b held=%0d drop=%b",
                   seen.deadline, seen.found, seen.head_kind, seen.head_ok,
                   seen.held, seen.dropped);
        end
      end
    end
  endtask

  // Sample every handshake at the clock edge. Check results before queueing
  // new predictions so that a stray early result is never matched.
  always @(posedge clk) begin : watch
    queue_status_t  got;
    pinned_status_t pin;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) spec_kind = cfg_data;
      if (out_tvalid && out_tready) score_result(out_tdata);
      if (in_tvalid && in_tready) begin
        got = apply_command(in_tuser, in_tdata[3:0], in_tdata[35:4], in_tdata[67:36]);
        pin = pinned_status.pop_front();
        pending_status.push_back(pin.typed ? pin.want : got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Close the current burst with a random gap, or keep streaming.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  // Offer one command and hold it until the block takes it.
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [KIND_W-1:0] kind,
                       input logic [DUE_W-1:0] tval, input logic [DUE_W-1:0] tnow,
                       input bit typed, input queue_status_t want);
    pinned_status_t pin;
    pin.typed = typed;
    pin.want  = want;
    pinned_status.push_back(pin);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, tnow, tval, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    pace();
  endtask

  // Stop sending and wait for every pending result to come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_special(input logic [KIND_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Draw one command. Segments bias the mix toward filling, draining or a
  // blend; a small share is raw noise across every field.
  task automatic draw_command(output logic [CMD_W-1:0] cmd, output logic [KIND_W-1:0] kind,
                              output logic [DUE_W-1:0] tval, output logic [DUE_W-1:0] tnow);
    int roll;
    int pick;
    if (seg_left == 0) begin
      seg_mode = seg_mode_t'($urandom_range(0, 2));
      seg_left = $urandom_range(10, 40);
    end
    seg_left--;

    // advance the cycle count, with rare jumps toward the wrap points
    roll = $urandom_range(0, 99);
    if (roll < 2)      now_cnt = 32'($urandom);
    else if (roll < 4) now_cnt = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
    else if (roll < 6) now_cnt = HALF_RANGE - 32'd64 + 32'($urandom_range(0, 128));
    else               now_cnt = now_cnt + 32'($urandom_range(0, 40));

    tval = 32'($urandom);
    tnow = now_cnt;
    roll = $urandom_range(0, 99);
    if (roll < 35)      kind = spec_kind;
    else if (roll < 75) kind = 4'($urandom_range(1, 3));
    else                kind = 4'($urandom_range(0, 15));

    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 8) begin
      cmd  = 3'($urandom_range(0, 7));
      kind = 4'($urandom);
      tnow = 32'($urandom);
    end else begin
      case (seg_mode)
        SEG_FILL:  cmd = (pick < 70) ? CMD_ADD_DELAY : (pick < 80) ? CMD_POP :
                         (pick < 92) ? CMD_FIND : CMD_REMOVE;
        SEG_DRAIN: cmd = (pick < 20) ? CMD_ADD_DELAY : (pick < 65) ? CMD_POP :
                         (pick < 80) ? CMD_REMOVE : CMD_FIND;
        default:   cmd = (pick < 40) ? CMD_ADD_DELAY : (pick < 58) ? CMD_POP :
                         (pick < 70) ? CMD_REMOVE : (pick < 90) ? CMD_FIND :
                         (pick < 96) ? CMD_CLEAR : (pick < 98) ? CMD_SPARE6 : CMD_SPARE7;
      endcase
      // split adds between relative and absolute forms
      if (cmd == CMD_ADD_DELAY && $urandom_range(0, 1) == 1) cmd = CMD_ADD_AT;
      roll = $urandom_range(0, 99);
      if (cmd == CMD_ADD_DELAY) begin
        if (roll < 80)      tval = 32'($urandom_range(0, 300));
        else if (roll < 90) tval = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      end else if (cmd == CMD_ADD_AT) begin
        if (roll < 60)      tval = now_cnt + 32'($urandom_range(0, 300));
        else if (roll < 80) tval = now_cnt - 32'($urandom_range(1, 1000));
        else if (roll < 90) tval = now_cnt - STALE_WINDOW - 32'($urandom_range(0, 1 << 20));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------

  // Stall on a pattern of its own: open, coin-flip or a fixed rhythm, each
  // held for a random stretch. rx_hold forces a long stall on top.
  initial begin : rx_pattern
    rx_mode_t mode;
    int       mode_left;
    int       tick;
    bit       ready;
    mode_left  = 0;
    tick       = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_OPEN: ready = 1'b1;
        RX_COIN: ready = ($urandom_range(0, 1) == 1);
        default: ready = (tick % 3 != 0);
      endcase
      out_tready <= ready && !rx_hold;
    end
  end

  // Hold off the receiver for a long stretch while the sender keeps going,
  // so the block backs up and drops in_tready.
  initial begin : rx_long_stall
    rx_hold <= 1'b0;
    @(posedge clk);
    while (items_sent < HOLD_AFTER) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : main
    logic [CMD_W-1:0]  cmd;
    logic [KIND_W-1:0] kind;
    logic [DUE_W-1:0]  tval;
    logic [DUE_W-1:0]  tnow;
    logic [KIND_W-1:0] setting [SETTINGS_RUN];
    int                waited;

    // model and counters at their reset state
    q_count       = 0;
    spec_done     = 1'b1;
    deadline_copy = '0;
    spec_kind     = '0;
    fail_count    = 0;
    items_sent    = 0;
    burst_left    = 0;
    now_cnt       = '0;
    seg_left      = 0;
    seg_mode      = SEG_MIX;
    setting       = '{4'd15, 4'd0, 4'($urandom), 4'd8, 4'($urandom), 4'd15};

    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan at the reset value of special_type
    foreach (plan[r])
      for (int n = 0; n < plan[r].reps; n++)
        offer(plan[r].cmd, plan[r].kind, plan[r].tval, plan[r].tnow,
              plan[r].typed, plan[r].want);

    // random sequences, one block per special_type setting
    for (int s = 0; s < SETTINGS_RUN; s++) begin
      write_special(setting[s]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        // once mid-run, pause the sender until every result is back
        if (s == 2 && i == RANDOM_ITEMS / 2) drain_results();
        draw_command(cmd, kind, tval, tnow);
        offer(cmd, kind, tval, tnow, 1'b0, ALL_ZERO);
      end
    end

    // let the tail of the traffic drain, bounded
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_status.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_status.size() != 0) begin
      $display("%0d predicted results never arrived", pending_status.size());
      fail_count += pending_status.size();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/wteq_pkg.sv
hw/rtl/wteq_cell.sv
hw/rtl/wraparound_timed_event_queue_top.sv
sim/wraparound_timed_event_queue_top_test.sv
